[rtl/dual_motor_angle_unwrap_tracker_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dual motor angle unwrap tracker
// Same-cycle and next-cycle implication checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_ANGLE_UNWRAP_TRACKER_TOP_MACROS_SVH
`define DUAL_MOTOR_ANGLE_UNWRAP_TRACKER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DMAUT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DMAUT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dmaut_pkg.sv]
// ----------------------------------------------------------------------------
// dmaut_pkg
// Types and constants shared by the dual motor angle unwrap tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package dmaut_pkg;

    localparam int ID_W      = 11;
    localparam int THR_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;
    localparam int VAL_W     = 16;
    localparam int CNT_W     = 8;
    localparam int TOTAL_W   = 30;

    localparam int COUNTS_PER_TURN = 8192;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [ID_W-1:0]  LEFT_ID_RST  = ID_W'(517);
    localparam logic [ID_W-1:0]  RIGHT_ID_RST = ID_W'(518);
    localparam logic [THR_W-1:0] WRAP_THR_RST = THR_W'(6500);

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ID  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ID = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THR = CFG_IDX_W'(2);

    localparam logic signed [VAL_W-1:0]   TURN_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0]   TURN_MIN = 16'sh8000;
    localparam logic [CNT_W-1:0]          CNT_MAX  = {CNT_W{1'b1}};
    localparam logic signed [TOTAL_W-1:0] CPT_S    = TOTAL_W'(COUNTS_PER_TURN);

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_TICK,
        CMD_LEFT,
        CMD_RIGHT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               kind;
        logic signed [VAL_W-1:0] angle;
        logic signed [VAL_W-1:0] speed;
    } t_cmd;

    typedef struct packed {
        logic              vld;
        logic [QCNT_W-1:0] count;
        t_cmd              cmd;
    } t_fq;

endpackage

`default_nettype wire

[rtl/dmaut_ifs.sv]
// ----------------------------------------------------------------------------
// dmaut channel interfaces
// Valid/ready channels for frame items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmaut_in_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [10:0]          frame_id;
    logic [7:0]           angle_high;
    logic [7:0]           angle_low;
    logic [7:0]           speed_high;
    logic [7:0]           speed_low;

    modport source (output valid, mode, frame_id, angle_high, angle_low,
                    speed_high, speed_low, input ready);
    modport sink   (input valid, mode, frame_id, angle_high, angle_low,
                    speed_high, speed_low, output ready);
endinterface

interface dmaut_out_if;
    logic                 valid;
    logic                 ready;
    logic                 matched;
    logic                 channel;
    logic signed [15:0]   angle_now;
    logic signed [15:0]   speed_now;
    logic signed [15:0]   turns;
    logic signed [29:0]   abs_angle;
    logic                 offline_left;
    logic                 offline_right;

    modport source (output valid, matched, channel, angle_now, speed_now, turns,
                    abs_angle, offline_left, offline_right, input ready);
    modport sink   (input valid, matched, channel, angle_now, speed_now, turns,
                    abs_angle, offline_left, offline_right, output ready);
endinterface

interface dmaut_cfg_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           index;
    logic [14:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/dmaut_front.sv]
// ----------------------------------------------------------------------------
// dmaut_front
// Configuration registers, frame classification and command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dmaut_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    dmaut_in_if.sink                          i_in,
    dmaut_cfg_if.sink                         i_cfg,
    input  wire logic                         i_pop,
    output      dmaut_pkg::t_fq               o_fq,
    output      logic [dmaut_pkg::THR_W-1:0]  o_wrap_thr
);
    import dmaut_pkg::*;

    logic [ID_W-1:0]   r_left_id;
    logic [ID_W-1:0]   r_right_id;
    logic [THR_W-1:0]  r_thr;
    t_cmd              r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    t_cmd              w_cmd;
    logic              w_push;
    logic              w_cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = (r_cnt != QCNT_W'(Q_DEPTH));
    assign w_push      = i_in.valid && i_in.ready;

    always_comb begin
        w_cmd.angle = signed'({i_in.angle_high, i_in.angle_low});
        w_cmd.speed = signed'({i_in.speed_high, i_in.speed_low});
        priority if (i_in.mode) begin
            w_cmd.kind = CMD_TICK;
        end else if (i_in.frame_id == r_left_id) begin
            w_cmd.kind = CMD_LEFT;
        end else if (i_in.frame_id == r_right_id) begin
            w_cmd.kind = CMD_RIGHT;
        end else begin
            w_cmd.kind = CMD_NONE;
        end
    end

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (w_push) begin
            n_wptr = (r_wptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
        end
        n_cnt = r_cnt + QCNT_W'(w_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_id  <= LEFT_ID_RST;
            r_right_id <= RIGHT_ID_RST;
            r_thr      <= WRAP_THR_RST;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_cnt      <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
            if (w_cfg_wr) begin
                unique case (i_cfg.index)
                    CFG_LEFT_ID:  r_left_id  <= i_cfg.data[ID_W-1:0];
                    CFG_RIGHT_ID: r_right_id <= i_cfg.data[ID_W-1:0];
                    CFG_WRAP_THR: r_thr      <= i_cfg.data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    assign o_fq.vld   = (r_cnt != '0);
    assign o_fq.count = r_cnt;
    assign o_fq.cmd   = r_q[r_rptr];
    assign o_wrap_thr = r_thr;

endmodule

`default_nettype wire

[rtl/dmaut_back.sv]
// ----------------------------------------------------------------------------
// dmaut_back
// Per-channel unwrap, turn count, frame counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmaut_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dmaut_pkg::t_fq               i_fq,
    input  wire logic [dmaut_pkg::THR_W-1:0]  i_wrap_thr,
    output      logic                         o_pop,
    dmaut_out_if.source                       o_out
);
    import dmaut_pkg::*;

    logic signed [VAL_W-1:0]   r_last_angle [2];
    logic signed [VAL_W-1:0]   r_turns      [2];
    logic [CNT_W-1:0]          r_fcnt       [2];
    logic                      r_offline    [2];
    logic signed [VAL_W-1:0]   n_last_angle [2];
    logic signed [VAL_W-1:0]   n_turns      [2];
    logic [CNT_W-1:0]          n_fcnt       [2];
    logic                      n_offline    [2];

    logic                      r_out_vld, n_out_vld;
    logic                      r_matched, n_matched;
    logic                      r_channel, n_channel;
    logic signed [VAL_W-1:0]   r_angle, n_angle;
    logic signed [VAL_W-1:0]   r_speed, n_speed;
    logic signed [VAL_W-1:0]   r_trn, n_trn;
    logic signed [TOTAL_W-1:0] r_total, n_total;

    logic                      w_ch;
    logic signed [VAL_W:0]     w_diff;
    logic signed [VAL_W:0]     w_thr;
    logic signed [VAL_W-1:0]   w_t;
    logic signed [VAL_W-1:0]   w_t_next;
    logic signed [TOTAL_W-1:0] w_total;

    assign o_pop = i_fq.vld && (!r_out_vld || o_out.ready);

    always_comb begin
        w_ch   = (i_fq.cmd.kind == CMD_RIGHT);
        w_thr  = signed'({2'b00, i_wrap_thr});
        w_diff = (VAL_W + 1)'(i_fq.cmd.angle) - (VAL_W + 1)'(r_last_angle[w_ch]);
        w_t    = r_turns[w_ch];
        priority if (w_diff < -w_thr) begin
            w_t_next = (w_t == TURN_MAX) ? w_t : w_t + VAL_W'(1);
        end else if (w_diff > w_thr) begin
            w_t_next = (w_t == TURN_MIN) ? w_t : w_t - VAL_W'(1);
        end else begin
            w_t_next = w_t;
        end
        w_total = TOTAL_W'(i_fq.cmd.angle) + TOTAL_W'(w_t_next) * CPT_S;
    end

    always_comb begin
        n_last_angle = r_last_angle;
        n_turns      = r_turns;
        n_fcnt       = r_fcnt;
        n_offline    = r_offline;
        n_out_vld    = o_out.ready ? 1'b0 : r_out_vld;
        n_matched    = r_matched;
        n_channel    = r_channel;
        n_angle      = r_angle;
        n_speed      = r_speed;
        n_trn        = r_trn;
        n_total      = r_total;
        if (o_pop) begin
            n_out_vld = 1'b1;
            n_matched = 1'b0;
            n_channel = 1'b0;
            n_angle   = '0;
            n_speed   = '0;
            n_trn     = '0;
            n_total   = '0;
            unique case (i_fq.cmd.kind)
                CMD_TICK: begin
                    for (int c = 0; c < 2; c++) begin
                        n_offline[c] = (r_fcnt[c] == '0);
                        n_fcnt[c]    = '0;
                    end
                end
                CMD_LEFT, CMD_RIGHT: begin
                    n_last_angle[w_ch] = i_fq.cmd.angle;
                    n_turns[w_ch]      = w_t_next;
                    if (r_fcnt[w_ch] != CNT_MAX) begin
                        n_fcnt[w_ch] = r_fcnt[w_ch] + CNT_W'(1);
                    end
                    n_matched = 1'b1;
                    n_channel = w_ch;
                    n_angle   = i_fq.cmd.angle;
                    n_speed   = i_fq.cmd.speed;
                    n_trn     = w_t_next;
                    n_total   = w_total;
                end
                CMD_NONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_last_angle[c] <= '0;
                r_turns[c]      <= '0;
                r_fcnt[c]       <= '0;
                r_offline[c]    <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_last_angle <= n_last_angle;
            r_turns      <= n_turns;
            r_fcnt       <= n_fcnt;
            r_offline    <= n_offline;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
        r_channel <= n_channel;
        r_angle   <= n_angle;
        r_speed   <= n_speed;
        r_trn     <= n_trn;
        r_total   <= n_total;
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.matched       = r_matched;
    assign o_out.channel       = r_channel;
    assign o_out.angle_now     = r_angle;
    assign o_out.speed_now     = r_speed;
    assign o_out.turns         = r_trn;
    assign o_out.abs_angle     = r_total;
    assign o_out.offline_left  = r_offline[0];
    assign o_out.offline_right = r_offline[1];

endmodule

`default_nettype wire

[rtl/dual_motor_angle_unwrap_tracker_top.sv]
// ----------------------------------------------------------------------------
// dual_motor_angle_unwrap_tracker_top
// Two-channel multi-turn angle tracker driven by feedback frame items.
//
// i_in carries frame items (mode 0) and offline check ticks (mode 1); i_cfg
// writes the left and right frame identifiers and the wrap threshold, and is
// always ready. o_out returns exactly one result per accepted item, in order.
// The front stage classifies an item against the identifiers and queues it in
// a two-entry command queue; the back stage updates the channel state and
// loads the result register. A result passes through the command queue and
// then the back-stage result register before it is valid. One item transfers
// per cycle while o_out keeps taking results; the per-channel state update in
// the back stage sets that rate. When o_out stalls the result holds, the back
// stage holds, and i_in keeps taking items until the queue is full.
// Reset restores the identifiers to 517 and 518, the threshold to 6500, and
// clears angles, turn counts, frame counters, offline flags and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_motor_angle_unwrap_tracker_top_macros.svh"

module dual_motor_angle_unwrap_tracker_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dmaut_in_if.sink     i_in,
    dmaut_cfg_if.sink    i_cfg,
    dmaut_out_if.source  o_out
);
    import dmaut_pkg::*;

    t_fq              w_fq;
    logic             w_pop;
    logic [THR_W-1:0] w_wrap_thr;

    dmaut_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (i_cfg),
        .i_pop      (w_pop),
        .o_fq       (w_fq),
        .o_wrap_thr (w_wrap_thr)
    );

    dmaut_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fq       (w_fq),
        .i_wrap_thr (w_wrap_thr),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

    `DMAUT_ASSERT_NOW(a_ready_only_when_not_full, !i_in.ready, w_fq.count == QCNT_W'(Q_DEPTH), "input stalled with queue not full")
    `DMAUT_ASSERT_NEXT(a_pop_loads_result, w_pop, o_out.valid, "popped command gave no result")
    `DMAUT_ASSERT_NOW(a_unmatched_zero, o_out.valid && !o_out.matched, o_out.turns == '0 && o_out.abs_angle == '0 && o_out.angle_now == '0, "unmatched result carries data")
    `DMAUT_ASSERT_NOW(a_total_consistent, o_out.valid && o_out.matched, o_out.abs_angle == TOTAL_W'(o_out.angle_now) + TOTAL_W'(o_out.turns) * CPT_S, "multi-turn angle mismatch")

endmodule

`default_nettype wire
